// File: rtl/lottery_ticket_scheduler_core_assert.svh
// ----------------------------------------------------------------------------
// Lottery ticket scheduler assertion macros
// Concurrent checks on i_clk, off while i_rst_n is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef LOTTERY_TICKET_SCHEDULER_CORE_ASSERT_SVH
`define LOTTERY_TICKET_SCHEDULER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("lts assertion failed");
// next-cycle implication
`define LTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("lts assertion failed");
`else
`define LTS_ASSERT_NOW(label, ante, cons)
`define LTS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg
// Shared constants and types of the lottery ticket scheduler.
// ----------------------------------------------------------------------------
package lts_pkg;

    localparam int MAX_TICKETS_DEF = 1024;
    localparam int WORKERS_DEF     = 16;
    localparam int TOTAL_RESET     = 1024;

    // random value and the radix-16 remainder unit
    localparam int RND_W     = 31;
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = (RND_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W     = DIV_STEPS * DIV_BITS;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_DRAW       = 2'd0;
    localparam logic [OP_W-1:0] OP_VALIDATE   = 2'd1;
    localparam logic [OP_W-1:0] OP_INVALIDATE = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_EVAL
    } t_state;

endpackage

// File: rtl/lts_ram.sv
// ----------------------------------------------------------------------------
// lts_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module lts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // read data holds until the next read
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/lottery_ticket_scheduler_core.sv
// ----------------------------------------------------------------------------
// lottery_ticket_scheduler_core
// Lottery scheduler over a RAM of tickets. Each RAM word holds a ticket's
// valid bit and its owning worker. A validate request marks a ticket valid and
// records its owner, an invalidate request clears it, and a draw request
// reduces i_random_value modulo the effective ticket count (the count
// register, with zero read as one and values above MAX_TICKETS saturated) and
// reports the owner of the drawn ticket, or status 1 when that ticket is not
// valid; there is no retry. Validate or invalidate of a ticket at or beyond
// the effective count, validate with an owner at or beyond WORKERS, and the
// unused operation code change nothing and return status 1. Every result
// carries the running count of valid tickets. One request is worked at a time.
// Validate and invalidate go from acceptance to result through three steps:
// accept, RAM read, read-modify-write. A draw adds the remainder unit, which
// retires 4 bits of the random value per cycle between acceptance and the RAM
// read. After reset the block sweeps the RAM, one entry per cycle, clearing
// all valid bits; o_in_ready stays low until the sweep has reached the end.
// Configuration writes are taken at any time on their own channel; change the
// count only while the block is idle. A finished result waits in the output
// register without holding up acceptance of the next request.
// ----------------------------------------------------------------------------
`include "lottery_ticket_scheduler_core_assert.svh"

module lottery_ticket_scheduler_core #(
    parameter int MAX_TICKETS = lts_pkg::MAX_TICKETS_DEF,
    parameter int WORKERS     = lts_pkg::WORKERS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    // count register write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [$clog2(MAX_TICKETS+1)-1:0]     i_total_tickets,

    // request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [lts_pkg::OP_W-1:0]             i_operation,
    input  logic [$clog2(MAX_TICKETS)-1:0]       i_ticket,
    input  logic [$clog2(WORKERS)-1:0]           i_owner,
    input  logic [lts_pkg::RND_W-1:0]            i_random_value,

    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_status,
    output logic [$clog2(WORKERS)-1:0]           o_winner,
    output logic [$clog2(MAX_TICKETS)-1:0]       o_drawn_ticket,
    output logic [$clog2(MAX_TICKETS+1)-1:0]     o_valid_count
);

    localparam int AW   = $clog2(MAX_TICKETS);      // ticket index
    localparam int CW   = $clog2(MAX_TICKETS + 1);  // counts
    localparam int OW   = $clog2(WORKERS);          // owner
    localparam int MW   = OW + 1;                   // RAM word: {valid, owner}
    localparam int RST_TOTAL = (lts_pkg::TOTAL_RESET > MAX_TICKETS) ?
                               MAX_TICKETS : lts_pkg::TOTAL_RESET;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TICKETS - 1);

    // one remainder digit: DIV_BITS restoring compare-subtract steps
    function automatic logic [CW-1:0] f_rem_step(
        input logic [CW-1:0]                rem,
        input logic [lts_pkg::DIV_BITS-1:0] bits,
        input logic [CW-1:0]                modulus
    );
        logic [CW:0]   t;
        logic [CW-1:0] r;
        r = rem;
        for (int i = lts_pkg::DIV_BITS - 1; i >= 0; i--) begin
            t = {r, bits[i]};
            if (t >= {1'b0, modulus}) begin
                t = t - {1'b0, modulus};
            end
            r = t[CW-1:0];
        end
        return r;
    endfunction

    // control state
    lts_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_clr_addr, n_clr_addr;
    logic [CW-1:0]   r_total;
    logic [CW-1:0]   r_live, n_live;
    logic            r_out_valid, n_out_valid;

    // request payload
    logic [lts_pkg::OP_W-1:0]   r_op, n_op;
    logic [AW-1:0]              r_addr, n_addr;
    logic [OW-1:0]              r_owner, n_owner;
    logic [CW-1:0]              r_n, n_n;
    logic [lts_pkg::DIV_W-1:0]  r_div, n_div;
    logic [CW-1:0]              r_rem, n_rem;
    logic [lts_pkg::STEP_W-1:0] r_step, n_step;

    // result register
    logic          r_status, n_status;
    logic [OW-1:0] r_winner, n_winner;
    logic [AW-1:0] r_drawn, n_drawn;
    logic [CW-1:0] r_count, n_count;

    // RAM port signals
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [MW-1:0] ram_wr_data;
    logic          ram_rd_en;
    logic [MW-1:0] ram_rd_data;

    logic [CW-1:0] eff_count;
    logic [CW-1:0] rem_next;
    logic          rd_valid;
    logic [OW-1:0] rd_owner;
    logic          tk_in_range;
    logic          own_in_range;
    logic          slot_free;

    lts_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_TICKETS)
    ) u_ticket_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (ram_rd_data)
    );

    // zero reads as one; above the table size saturates
    assign eff_count = (r_total == '0) ? CW'(1) :
                       ((r_total > CW'(MAX_TICKETS)) ? CW'(MAX_TICKETS) : r_total);

    assign rem_next = f_rem_step(r_rem,
                                 r_div[lts_pkg::DIV_W-1 -: lts_pkg::DIV_BITS], r_n);

    assign rd_valid     = ram_rd_data[MW-1];
    assign rd_owner     = ram_rd_data[OW-1:0];
    assign tk_in_range  = CW'(r_addr) < r_n;
    assign own_in_range = {1'b0, r_owner} < (OW + 1)'(WORKERS);
    assign slot_free    = !r_out_valid || i_out_ready;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == lts_pkg::ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_live      = r_live;
        n_out_valid = r_out_valid;
        n_op        = r_op;
        n_addr      = r_addr;
        n_owner     = r_owner;
        n_n         = r_n;
        n_div       = r_div;
        n_rem       = r_rem;
        n_step      = r_step;
        n_status    = r_status;
        n_winner    = r_winner;
        n_drawn     = r_drawn;
        n_count     = r_count;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_addr;
        ram_wr_data = {1'b1, r_owner};
        ram_rd_en   = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            lts_pkg::ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr_addr;
                ram_wr_data = '0;
                n_clr_addr  = r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = lts_pkg::ST_IDLE;
                end
            end
            lts_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_operation;
                    n_addr  = i_ticket;
                    n_owner = i_owner;
                    n_n     = eff_count;
                    n_div   = lts_pkg::DIV_W'(i_random_value);
                    n_rem   = '0;
                    n_step  = lts_pkg::STEP_W'(lts_pkg::DIV_STEPS - 1);
                    n_state = (i_operation == lts_pkg::OP_DRAW) ?
                              lts_pkg::ST_DIV : lts_pkg::ST_READ;
                end
            end
            lts_pkg::ST_DIV: begin
                n_rem = rem_next;
                n_div = r_div << lts_pkg::DIV_BITS;
                n_step = r_step - lts_pkg::STEP_W'(1);
                if (r_step == '0) begin
                    n_addr  = rem_next[AW-1:0];
                    n_state = lts_pkg::ST_READ;
                end
            end
            lts_pkg::ST_READ: begin
                ram_rd_en = 1'b1;
                n_state   = lts_pkg::ST_EVAL;
            end
            lts_pkg::ST_EVAL: begin
                // read data holds while waiting for the output slot
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_status    = 1'b1;
                    n_winner    = '0;
                    n_drawn     = '0;
                    n_state     = lts_pkg::ST_IDLE;
                    case (r_op)
                        lts_pkg::OP_DRAW: begin
                            n_drawn = r_addr;
                            if (rd_valid) begin
                                n_status = 1'b0;
                                n_winner = rd_owner;
                            end
                        end
                        lts_pkg::OP_VALIDATE: begin
                            if (tk_in_range && own_in_range) begin
                                ram_wr_en   = 1'b1;
                                ram_wr_data = {1'b1, r_owner};
                                n_status    = 1'b0;
                                if (!rd_valid) begin
                                    n_live = r_live + CW'(1);
                                end
                            end
                        end
                        lts_pkg::OP_INVALIDATE: begin
                            if (tk_in_range) begin
                                n_status = 1'b0;
                                if (rd_valid) begin
                                    ram_wr_en   = 1'b1;
                                    ram_wr_data = {1'b0, rd_owner};
                                    n_live      = r_live - CW'(1);
                                end
                            end
                        end
                        default: begin
                            n_status = 1'b1;
                        end
                    endcase
                    n_count = n_live;
                end
            end
            default: begin
                n_state = lts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lts_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
            r_total     <= CW'(RST_TOTAL);
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_total <= i_total_tickets;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_addr   <= n_addr;
        r_owner  <= n_owner;
        r_n      <= n_n;
        r_div    <= n_div;
        r_rem    <= n_rem;
        r_step   <= n_step;
        r_status <= n_status;
        r_winner <= n_winner;
        r_drawn  <= n_drawn;
        r_count  <= n_count;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_winner       = r_winner;
    assign o_drawn_ticket = r_drawn;
    assign o_valid_count  = r_count;

    // RAM read and write never share a cycle
    `LTS_ASSERT_NOW(a_no_rd_wr_overlap, ram_wr_en, !ram_rd_en)
    // drawn ticket is always below the modulus
    `LTS_ASSERT_NOW(a_draw_in_range, (r_state == lts_pkg::ST_READ) && (r_op == lts_pkg::OP_DRAW), CW'(r_addr) < r_n)
    // a finished request always lands in the output register
    `LTS_ASSERT_NEXT(a_result_loaded, (r_state == lts_pkg::ST_EVAL) && slot_free, o_out_valid)
    // live count never exceeds the table size
    `LTS_ASSERT_NOW(a_live_bound, 1'b1, r_live <= CW'(MAX_TICKETS))

endmodule
